[hw/rtl/wcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg: shared types and helpers of the washer cycle sequencer
// Phase codes, register indexes, state and configuration records, and the
// small helper functions used by the cycle update logic.
// ----------------------------------------------------------------------------
package wcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FILL  = 3'd1,
    PH_SOAK  = 3'd2,
    PH_WASH  = 3'd3,
    PH_DRAIN = 3'd4,
    PH_SPIN  = 3'd5,
    PH_RINSE = 3'd6,
    PH_DONE  = 3'd7
  } phase_e;

  localparam logic [2:0] CFG_SOAK_MS      = 3'd0;
  localparam logic [2:0] CFG_WASH_MS      = 3'd1;
  localparam logic [2:0] CFG_RINSE_MS     = 3'd2;
  localparam logic [2:0] CFG_SPIN_MS      = 3'd3;
  localparam logic [2:0] CFG_DONE_MS      = 3'd4;
  localparam logic [2:0] CFG_PAUSE_MIN_MS = 3'd5;
  localparam logic [2:0] CFG_WASH_STEP_MS = 3'd6;
  localparam logic [2:0] CFG_SPIN_STEP_MS = 3'd7;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [16:0] CNT17_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [15:0] soak_ms;
    logic [15:0] wash_ms;
    logic [15:0] rinse_ms;
    logic [15:0] spin_ms;
    logic [15:0] done_ms;
    logic [15:0] pause_min_ms;
    logic [9:0]  wash_step_ms;
    logic [9:0]  spin_step_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    soak_ms:      16'd5000,
    wash_ms:      16'd15000,
    rinse_ms:     16'd15000,
    spin_ms:      16'd13000,
    done_ms:      16'd5000,
    pause_min_ms: 16'd1000,
    wash_step_ms: 10'd30,
    spin_step_ms: 10'd10
  };

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  round_cnt;
    logic [16:0] phase_el;
    logic [9:0]  step_el;
    logic [2:0]  chaser_pos;
    logic        pause_flag;
    logic [16:0] pause_el;
    logic [2:0]  prev_in;
    logic [7:0]  led_hold;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_IDLE,
    round_cnt:  2'd0,
    phase_el:   17'd0,
    step_el:    10'd0,
    chaser_pos: 3'd0,
    pause_flag: 1'b0,
    pause_el:   17'd0,
    prev_in:    3'b111,
    led_hold:   8'd0
  };

  function automatic logic [16:0] sat_inc17(logic [16:0] v);
    return (v == CNT17_MAX) ? CNT17_MAX : v + 17'd1;
  endfunction

  function automatic state_t enter_phase(state_t s, phase_e p);
    state_t r;
    r            = s;
    r.phase      = p;
    r.phase_el   = '0;
    r.step_el    = '0;
    r.chaser_pos = '0;
    return r;
  endfunction

  function automatic logic [7:0] led_pattern(phase_e ph, logic [2:0] pos);
    logic on;
    logic [7:0] pat;
    on = ~pos[0];
    case (ph) inside
      PH_FILL:                    pat = {7'd0, on};
      PH_SOAK:                    pat = {6'd0, on, 1'b0};
      PH_DRAIN:                   pat = {5'd0, on, 2'd0};
      PH_DONE:                    pat = {2'd0, on, 5'd0};
      PH_WASH, PH_SPIN, PH_RINSE: pat = 8'd1 << pos;
      default:                    pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

[hw/rtl/wcs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_step: one-tick update of the washer cycle state
// Computes the next phase, timers, chaser position, pause status and LED
// pattern from the current state, the configuration and one input sample.
// ----------------------------------------------------------------------------
module wcs_step #(
  parameter int unsigned RINSE_ROUNDS  = 2,
  parameter int unsigned BLINK_HALF_MS = 50
) (
  input  wcs_pkg::state_t state_i,
  input  wcs_pkg::cfg_t   cfg_i,
  input  logic            start_n_i,
  input  logic            pause_n_i,
  input  logic            level_n_i,
  output wcs_pkg::state_t state_o
);

  localparam logic [10:0] BlinkHalf = 11'(BLINK_HALF_MS);
  localparam logic [2:0]  Rounds    = 3'(RINSE_ROUNDS);

  logic [2:0]      cur;
  logic [2:0]      fall;
  logic [9:0]      step_sel;
  logic [9:0]      step_eff;
  logic [15:0]     dur_sel;
  logic [15:0]     tmr_dur;
  logic [16:0]     ph_el_inc;
  logic [10:0]     step_next;
  logic            chase_wrap;
  logic            sweep_done;
  logic            blink_wrap;
  wcs_pkg::state_t s;

  assign cur  = {level_n_i, pause_n_i, start_n_i};
  assign fall = state_i.prev_in & ~cur;

  assign step_sel  = (state_i.phase == wcs_pkg::PH_SPIN) ? cfg_i.spin_step_ms
                                                         : cfg_i.wash_step_ms;
  assign step_eff  = (step_sel == 10'd0) ? 10'd1 : step_sel;
  assign dur_sel   = (state_i.phase == wcs_pkg::PH_SPIN) ? cfg_i.spin_ms :
                     (state_i.phase == wcs_pkg::PH_WASH) ? cfg_i.wash_ms : cfg_i.rinse_ms;
  assign tmr_dur   = (state_i.phase == wcs_pkg::PH_SOAK) ? cfg_i.soak_ms : cfg_i.done_ms;
  assign ph_el_inc = wcs_pkg::sat_inc17(state_i.phase_el);
  assign step_next = {1'b0, state_i.step_el} + 11'd1;

  assign chase_wrap = step_next >= {1'b0, step_eff};
  assign sweep_done = chase_wrap && (state_i.chaser_pos == 3'd7)
                      && (ph_el_inc > {1'b0, dur_sel});
  assign blink_wrap = step_next >= BlinkHalf;

  always_comb begin
    s = state_i;
    if (state_i.pause_flag) begin
      if (!cur[1] && (state_i.pause_el > {1'b0, cfg_i.pause_min_ms})) begin
        s.pause_flag = 1'b0;
      end else begin
        s.pause_el = wcs_pkg::sat_inc17(state_i.pause_el);
      end
    end else if (state_i.phase == wcs_pkg::PH_IDLE) begin
      if (fall[0]) begin
        s.round_cnt = 2'd0;
        s = wcs_pkg::enter_phase(s, wcs_pkg::PH_FILL);
      end
    end else if (fall[1]) begin
      s.pause_flag = 1'b1;
      s.pause_el   = '0;
    end else begin
      case (state_i.phase) inside
        wcs_pkg::PH_FILL, wcs_pkg::PH_DRAIN, wcs_pkg::PH_SOAK, wcs_pkg::PH_DONE: begin
          if (blink_wrap) begin
            s.step_el       = '0;
            s.chaser_pos[0] = ~state_i.chaser_pos[0];
          end else begin
            s.step_el = step_next[9:0];
          end
          if (state_i.phase == wcs_pkg::PH_FILL) begin
            if (fall[2]) begin
              s = wcs_pkg::enter_phase(s, (state_i.round_cnt == 2'd0) ?
                                          wcs_pkg::PH_SOAK : wcs_pkg::PH_RINSE);
            end
          end else if (state_i.phase == wcs_pkg::PH_DRAIN) begin
            if (fall[2]) begin
              s = wcs_pkg::enter_phase(s, wcs_pkg::PH_SPIN);
            end
          end else begin
            s.phase_el = ph_el_inc;
            if (ph_el_inc > {1'b0, tmr_dur}) begin
              s = wcs_pkg::enter_phase(s, (state_i.phase == wcs_pkg::PH_SOAK) ?
                                          wcs_pkg::PH_WASH : wcs_pkg::PH_IDLE);
            end
          end
        end
        default: begin
          s.phase_el = ph_el_inc;
          if (sweep_done) begin
            if (state_i.phase != wcs_pkg::PH_SPIN) begin
              s = wcs_pkg::enter_phase(s, wcs_pkg::PH_DRAIN);
            end else if ({1'b0, state_i.round_cnt} < Rounds) begin
              s.round_cnt = state_i.round_cnt + 2'd1;
              s = wcs_pkg::enter_phase(s, wcs_pkg::PH_FILL);
            end else begin
              s = wcs_pkg::enter_phase(s, wcs_pkg::PH_DONE);
            end
          end else if (chase_wrap) begin
            s.step_el    = '0;
            s.chaser_pos = state_i.chaser_pos + 3'd1;
          end else begin
            s.step_el = step_next[9:0];
          end
        end
      endcase
    end
    s.prev_in = cur;
    if (!s.pause_flag) begin
      s.led_hold = wcs_pkg::led_pattern(s.phase, s.chaser_pos);
    end
    state_o = s;
  end

endmodule

[hw/rtl/washer_cycle_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// washer_cycle_sequencer: washing-machine cycle controller
// Takes one millisecond tick per input transaction and returns the LED
// pattern, the current phase and the pause status after that tick.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  input    | in_valid_i / in_stall_o   | start_n_i, pause_n_i, level_n_i
//  output   | out_valid_o / out_stall_i | leds_o, phase_o, paused_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
//  Each tick is applied combinationally; its result is registered and visible the cycle after.
//  A new tick is taken every cycle while the result register is free or
//  being emptied in the same cycle.
//  A stalled result holds, and further input transactions wait behind it.
//  Reset returns the cycle to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module washer_cycle_sequencer #(
  parameter int unsigned RINSE_ROUNDS  = 2,
  parameter int unsigned BLINK_HALF_MS = 50
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_n_i,
  input  logic                         pause_n_i,
  input  logic                         level_n_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   leds_o,
  output logic [2:0]                   phase_o,
  output logic                         paused_o,
  input  logic                         cfg_we_i,
  input  logic [wcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wcs_pkg::CfgDataW-1:0] cfg_data_i
);

  wcs_pkg::cfg_t   cfg_q;
  wcs_pkg::state_t state_q;
  wcs_pkg::state_t state_d;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            in_accept;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  wcs_step #(
    .RINSE_ROUNDS (RINSE_ROUNDS),
    .BLINK_HALF_MS(BLINK_HALF_MS)
  ) u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .start_n_i(start_n_i),
    .pause_n_i(pause_n_i),
    .level_n_i(level_n_i),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcs_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wcs_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wcs_pkg::CFG_SOAK_MS:      cfg_q.soak_ms      <= cfg_data_i;
        wcs_pkg::CFG_WASH_MS:      cfg_q.wash_ms      <= cfg_data_i;
        wcs_pkg::CFG_RINSE_MS:     cfg_q.rinse_ms     <= cfg_data_i;
        wcs_pkg::CFG_SPIN_MS:      cfg_q.spin_ms      <= cfg_data_i;
        wcs_pkg::CFG_DONE_MS:      cfg_q.done_ms      <= cfg_data_i;
        wcs_pkg::CFG_PAUSE_MIN_MS: cfg_q.pause_min_ms <= cfg_data_i;
        wcs_pkg::CFG_WASH_STEP_MS: cfg_q.wash_step_ms <= cfg_data_i[9:0];
        wcs_pkg::CFG_SPIN_STEP_MS: cfg_q.spin_step_ms <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign leds_o      = state_q.led_hold;
  assign phase_o     = state_q.phase;
  assign paused_o    = state_q.pause_flag;

endmodule

[hw/rtl/wcs_sva.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_sva: port-level checks of the washer cycle sequencer
// Watches the top-level ports and flags dropped or missing results, results
// the cycle logic never produces, and result changes with no input transaction.
// ----------------------------------------------------------------------------
module wcs_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] leds_o,
  input logic [2:0] phase_o,
  input logic       paused_o
);

  logic in_accept;

  assign in_accept = in_valid_i & ~in_stall_o;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("An accepted transaction produced no result.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("A stalled result was dropped.");

  a_quiet_without_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(phase_o) && $stable(leds_o) && $stable(paused_o))
    else $error("The result changed without an input transaction.");

  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (phase_o == wcs_pkg::PH_IDLE) |-> (leds_o == 8'd0) && !paused_o)
    else $error("The idle phase shows LEDs or a pause.");

  a_single_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(leds_o))
    else $error("More than one LED is lit.");

endmodule

bind washer_cycle_sequencer wcs_sva u_wcs_sva (.*);

[dv/tb_washer_cycle_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_washer_cycle_sequencer: self-checking testbench of the washer cycle
// sequencer
// Drives one millisecond tick per input transaction and predicts the LED
// pattern, phase and pause status of every tick with a cycle-level model
// kept inside the bench. Directed tests cover ignored button edges, start,
// pause and resume, zero durations and zero step times, and a long pause
// under the largest settings. Randomized tests run well-formed wash cycles
// with noisy buttons under several register settings and handshake idling
// patterns.
// ----------------------------------------------------------------------------
module tb_washer_cycle_sequencer;

  localparam int unsigned RINSE_ROUNDS   = 2;
  localparam int unsigned BLINK_HALF_MS  = 50;
  localparam int          RESET_CYCLES   = 12;
  localparam int          RESULT_LATENCY = 2;
  localparam int          QUIET_LIMIT    = 2000;
  localparam int          MAX_REPORTED   = 10;
  localparam int          CHUNK_TICKS    = 300;
  localparam int          LONG_PAUSE_MS  = 200;
  localparam logic [16:0] ELAPSED_CEIL   = 17'h1FFFF;

  typedef struct packed {
    logic [7:0]      leds;
    wcs_pkg::phase_e phase;
    logic            paused;
  } tick_result_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic                         start_n_i   = 1'b1;
  logic                         pause_n_i   = 1'b1;
  logic                         level_n_i   = 1'b1;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [7:0]                   leds_o;
  logic [2:0]                   phase_o;
  logic                         paused_o;
  logic                         cfg_we_i    = 1'b0;
  logic [wcs_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [wcs_pkg::CfgDataW-1:0] cfg_data_i  = '0;

  // Cycle model state and register copies.
  logic [15:0]     reg_val [8];
  wcs_pkg::phase_e ph_q;
  logic [1:0]      round_q;
  logic [16:0]     ph_el_q;
  logic [9:0]      step_el_q;
  logic [2:0]      pos_q;
  logic            frozen_q;
  logic [16:0]     frz_el_q;
  logic [2:0]      prev_q;
  logic [7:0]      held_q;

  tick_result_t expected_ticks[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;

  // Button levels of the randomized traffic.
  logic start_lvl  = 1'b1;
  logic pause_lvl  = 1'b1;
  logic level_lvl  = 1'b1;
  int   pause_left = 0;

  washer_cycle_sequencer #(
    .RINSE_ROUNDS (RINSE_ROUNDS),
    .BLINK_HALF_MS(BLINK_HALF_MS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .start_n_i  (start_n_i),
    .pause_n_i  (pause_n_i),
    .level_n_i  (level_n_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .leds_o     (leds_o),
    .phase_o    (phase_o),
    .paused_o   (paused_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [16:0] bump17(logic [16:0] v);
    return (v >= ELAPSED_CEIL) ? v : v + 17'd1;
  endfunction

  function automatic void go_phase(wcs_pkg::phase_e nxt);
    ph_q      = nxt;
    ph_el_q   = '0;
    step_el_q = '0;
    pos_q     = '0;
  endfunction

  function automatic void blink_tick();
    int unsigned nxt;
    nxt = int'(step_el_q) + 1;
    if (nxt >= BLINK_HALF_MS) begin
      step_el_q = '0;
      pos_q[0]  = ~pos_q[0];
    end else begin
      step_el_q = 10'(nxt);
    end
  endfunction

  // Returns 1 when the sweep has finished and the phase time is over.
  function automatic logic sweep_tick(logic [9:0] step_ms, logic [15:0] dur);
    int unsigned st;
    int unsigned nxt;
    st      = (step_ms == 10'd0) ? 1 : int'(step_ms);
    nxt     = int'(step_el_q) + 1;
    ph_el_q = bump17(ph_el_q);
    if (nxt < st) begin
      step_el_q = 10'(nxt);
      return 1'b0;
    end
    step_el_q = '0;
    if (pos_q == 3'd7 && ph_el_q > dur) begin
      return 1'b1;
    end
    pos_q = pos_q + 3'd1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] lamp_pattern();
    logic [7:0] pat;
    logic       lit;
    pat = '0;
    lit = ~pos_q[0];
    case (ph_q) inside
      wcs_pkg::PH_FILL:  pat[0] = lit;
      wcs_pkg::PH_SOAK:  pat[1] = lit;
      wcs_pkg::PH_DRAIN: pat[2] = lit;
      wcs_pkg::PH_DONE:  pat[5] = lit;
      wcs_pkg::PH_WASH, wcs_pkg::PH_SPIN, wcs_pkg::PH_RINSE: pat[pos_q] = 1'b1;
      default:           pat    = '0;
    endcase
    return pat;
  endfunction

  task automatic reset_model();
    reg_val[wcs_pkg::CFG_SOAK_MS]      = 16'd5000;
    reg_val[wcs_pkg::CFG_WASH_MS]      = 16'd15000;
    reg_val[wcs_pkg::CFG_RINSE_MS]     = 16'd15000;
    reg_val[wcs_pkg::CFG_SPIN_MS]      = 16'd13000;
    reg_val[wcs_pkg::CFG_DONE_MS]      = 16'd5000;
    reg_val[wcs_pkg::CFG_PAUSE_MIN_MS] = 16'd1000;
    reg_val[wcs_pkg::CFG_WASH_STEP_MS] = 16'd30;
    reg_val[wcs_pkg::CFG_SPIN_STEP_MS] = 16'd10;
    go_phase(wcs_pkg::PH_IDLE);
    round_q  = '0;
    frozen_q = 1'b0;
    frz_el_q = '0;
    prev_q   = 3'b111;
    held_q   = '0;
  endtask

  task automatic predict_tick(input logic s_n, input logic p_n, input logic l_n);
    logic [2:0]   now_in;
    logic [2:0]   falls;
    tick_result_t r;
    now_in = {l_n, p_n, s_n};
    falls  = prev_q & ~now_in;
    if (frozen_q) begin
      if (!p_n && frz_el_q > reg_val[wcs_pkg::CFG_PAUSE_MIN_MS]) begin
        frozen_q = 1'b0;
      end else begin
        frz_el_q = bump17(frz_el_q);
      end
    end else if (ph_q == wcs_pkg::PH_IDLE) begin
      if (falls[0]) begin
        round_q = '0;
        go_phase(wcs_pkg::PH_FILL);
      end
    end else if (falls[1]) begin
      frozen_q = 1'b1;
      frz_el_q = '0;
    end else begin
      case (ph_q)
        wcs_pkg::PH_FILL: begin
          blink_tick();
          if (falls[2]) begin
            go_phase((round_q == 2'd0) ? wcs_pkg::PH_SOAK : wcs_pkg::PH_RINSE);
          end
        end
        wcs_pkg::PH_DRAIN: begin
          blink_tick();
          if (falls[2]) begin
            go_phase(wcs_pkg::PH_SPIN);
          end
        end
        wcs_pkg::PH_SOAK: begin
          blink_tick();
          ph_el_q = bump17(ph_el_q);
          if (ph_el_q > reg_val[wcs_pkg::CFG_SOAK_MS]) begin
            go_phase(wcs_pkg::PH_WASH);
          end
        end
        wcs_pkg::PH_DONE: begin
          blink_tick();
          ph_el_q = bump17(ph_el_q);
          if (ph_el_q > reg_val[wcs_pkg::CFG_DONE_MS]) begin
            go_phase(wcs_pkg::PH_IDLE);
          end
        end
        wcs_pkg::PH_WASH: begin
          if (sweep_tick(reg_val[wcs_pkg::CFG_WASH_STEP_MS][9:0],
                         reg_val[wcs_pkg::CFG_WASH_MS])) begin
            go_phase(wcs_pkg::PH_DRAIN);
          end
        end
        wcs_pkg::PH_RINSE: begin
          if (sweep_tick(reg_val[wcs_pkg::CFG_WASH_STEP_MS][9:0],
                         reg_val[wcs_pkg::CFG_RINSE_MS])) begin
            go_phase(wcs_pkg::PH_DRAIN);
          end
        end
        wcs_pkg::PH_SPIN: begin
          if (sweep_tick(reg_val[wcs_pkg::CFG_SPIN_STEP_MS][9:0],
                         reg_val[wcs_pkg::CFG_SPIN_MS])) begin
            if (round_q < RINSE_ROUNDS) begin
              round_q = round_q + 2'd1;
              go_phase(wcs_pkg::PH_FILL);
            end else begin
              go_phase(wcs_pkg::PH_DONE);
            end
          end
        end
        default: ;
      endcase
    end
    prev_q = now_in;
    if (!frozen_q) begin
      held_q = lamp_pattern();
    end
    r.leds   = held_q;
    r.phase  = ph_q;
    r.paused = frozen_q;
    expected_ticks.push_back(r);
  endtask

  task automatic send_tick(input logic s_n, input logic p_n, input logic l_n);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_n_i  <= s_n;
    pause_n_i  <= p_n;
    level_n_i  <= l_n;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_tick(s_n, p_n, l_n);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_ticks.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (RESULT_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    reg_val[idx] = value;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_duration();
    return ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(60));
  endfunction

  function automatic logic [15:0] pick_step();
    return ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(4, 1));
  endfunction

  task automatic randomize_registers();
    write_reg(wcs_pkg::CFG_SOAK_MS, pick_duration());
    write_reg(wcs_pkg::CFG_WASH_MS, pick_duration());
    write_reg(wcs_pkg::CFG_RINSE_MS, pick_duration());
    write_reg(wcs_pkg::CFG_SPIN_MS, pick_duration());
    write_reg(wcs_pkg::CFG_DONE_MS, pick_duration());
    write_reg(wcs_pkg::CFG_PAUSE_MIN_MS, 16'($urandom_range(20)));
    write_reg(wcs_pkg::CFG_WASH_STEP_MS, pick_step());
    write_reg(wcs_pkg::CFG_SPIN_STEP_MS, pick_step());
  endtask

  // Button activity that follows the cycle: start presses while idle, level
  // drops during fill and drain, and pause presses mostly held long enough
  // to resume, with some noise everywhere else.
  task automatic random_tick();
    logic        tank_phase;
    int unsigned hold_min;
    tank_phase = !frozen_q && (ph_q == wcs_pkg::PH_FILL || ph_q == wcs_pkg::PH_DRAIN);
    hold_min   = 32'(reg_val[wcs_pkg::CFG_PAUSE_MIN_MS]);
    start_lvl  = ($urandom_range(99) >= ((ph_q == wcs_pkg::PH_IDLE) ? 25 : 2));
    if (level_lvl) begin
      level_lvl = ($urandom_range(tank_phase ? 5 : 24) != 0);
    end else begin
      level_lvl = 1'($urandom_range(1));
    end
    if (pause_left > 0) begin
      pause_lvl = 1'b0;
      pause_left--;
    end else if ($urandom_range(frozen_q ? 9 : 199) == 0) begin
      pause_lvl = 1'b0;
      if (frozen_q) begin
        pause_left = $urandom_range(3);
      end else if ($urandom_range(3) != 0) begin
        pause_left = $urandom_range(hold_min + 6, hold_min + 1);
      end else begin
        pause_left = $urandom_range(hold_min);
      end
    end else begin
      pause_lvl = 1'b1;
    end
    send_tick(start_lvl, pause_lvl, level_lvl);
  endtask

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTED) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    tick_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_ticks.size() == 0) begin
        flag_mismatch($sformatf("result %0d with nothing expected: leds %02h phase %0d paused %0b",
                                results_seen, leds_o, phase_o, paused_o));
      end else begin
        want = expected_ticks.pop_front();
        if (leds_o !== want.leds) begin
          flag_mismatch($sformatf("result %0d leds: expected %02h, got %02h",
                                  results_seen, want.leds, leds_o));
        end
        if (phase_o !== want.phase) begin
          flag_mismatch($sformatf("result %0d phase: expected %0d, got %0d",
                                  results_seen, want.phase, phase_o));
        end
        if (paused_o !== want.paused) begin
          flag_mismatch($sformatf("result %0d paused: expected %0b, got %0b",
                                  results_seen, want.paused, paused_o));
        end
      end
    end
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("washer_cycle_sequencer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_idle_ignores_edges();
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_start_and_pause();
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
  endtask

  // All durations and step times at zero, so each phase ends as early as it can.
  task automatic test_zero_settings();
    drain_results();
    write_reg(wcs_pkg::CFG_SOAK_MS, 16'd0);
    write_reg(wcs_pkg::CFG_WASH_MS, 16'd0);
    write_reg(wcs_pkg::CFG_RINSE_MS, 16'd0);
    write_reg(wcs_pkg::CFG_SPIN_MS, 16'd0);
    write_reg(wcs_pkg::CFG_DONE_MS, 16'd0);
    write_reg(wcs_pkg::CFG_PAUSE_MIN_MS, 16'd0);
    write_reg(wcs_pkg::CFG_WASH_STEP_MS, 16'd0);
    write_reg(wcs_pkg::CFG_SPIN_STEP_MS, 16'd0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
    repeat (9) send_tick(1'b1, 1'b1, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (2) begin
      drain_results();
      randomize_registers();
      repeat (CHUNK_TICKS) random_tick();
    end
  endtask

  // Longest durations and long step times, then a pause left released past its
  // minimum time. A press at exactly the minimum keeps the pause, the next
  // press resumes it.
  task automatic test_long_pause();
    drain_results();
    write_reg(wcs_pkg::CFG_PAUSE_MIN_MS, 16'd0);
    write_reg(wcs_pkg::CFG_SOAK_MS, 16'hFFFF);
    write_reg(wcs_pkg::CFG_WASH_MS, 16'hFFFF);
    write_reg(wcs_pkg::CFG_RINSE_MS, 16'hFFFF);
    write_reg(wcs_pkg::CFG_SPIN_MS, 16'hFFFF);
    write_reg(wcs_pkg::CFG_DONE_MS, 16'hFFFF);
    write_reg(wcs_pkg::CFG_WASH_STEP_MS, 16'd1000);
    write_reg(wcs_pkg::CFG_SPIN_STEP_MS, 16'd1023);
    while (frozen_q || ph_q == wcs_pkg::PH_IDLE) begin
      if (frozen_q) begin
        send_tick(1'b1, 1'b0, 1'b1);
      end else begin
        send_tick(prev_q[0] ? 1'b0 : 1'b1, 1'b1, 1'b1);
      end
    end
    send_tick(1'b1, 1'b1, 1'b1);
    drain_results();
    write_reg(wcs_pkg::CFG_PAUSE_MIN_MS, 16'(LONG_PAUSE_MS));
    send_tick(1'b1, 1'b0, 1'b1);
    repeat (LONG_PAUSE_MS) send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1);
    repeat (3) send_tick(1'b1, 1'b1, 1'b1);
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 31;
    recv_idle_pct = 64;
    test_idle_ignores_edges();
    test_start_and_pause();
    test_zero_settings();
    test_random_traffic(31, 64);
    test_random_traffic(64, 31);
    test_random_traffic(0, 0);
    test_long_pause();
    drain_results();
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("washer_cycle_sequencer regression: pass");
    end else begin
      $display("washer_cycle_sequencer regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/wcs_pkg.sv
hw/rtl/wcs_step.sv
hw/rtl/washer_cycle_sequencer.sv
hw/rtl/wcs_sva.sv
dv/tb_washer_cycle_sequencer.sv
